@@ rtl/remote_packet_decoder_macros.svh @@
// Assertion helpers for the decoder RTL.
`ifndef REMOTE_PACKET_DECODER_MACROS_SVH
`define REMOTE_PACKET_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rpd_pkg.sv @@
`timescale 1ns / 1ps

package rpd_pkg;

    localparam int PACKET_BYTES = 32;
    localparam int IDX_W        = $clog2(PACKET_BYTES);
    localparam int FIELD_DEPTH  = 10;
    localparam int STICK_BYTES  = 8;
    localparam int SUM_W        = 13;
    localparam int THR_W        = 13;
    localparam int TRIM_W       = 15;
    localparam int ANGLE_W      = 16;
    localparam int YAW_W        = 15;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 3;

    // Byte positions inside a packet, and slots in the field store.
    localparam int FIELD_FIRST  = 2;
    localparam int FIELD_LAST   = 10;
    localparam int KEY_SLOT     = 8;
    localparam int CHECK_SLOT   = 9;

    localparam logic [SUM_W-1:0] SUM_LIMIT = 13'd7500;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] KEY_ALT = 2'd1;
    localparam logic [1:0] KEY_AUX = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RELEASE_THRESHOLD = 3'd0,
        CFG_RISE_LIMIT        = 3'd1,
        CFG_FAIL_LIMIT        = 3'd2,
        CFG_ROLL_TRIM         = 3'd3,
        CFG_PITCH_TRIM        = 3'd4,
        CFG_THROTTLE_MIN      = 3'd5,
        CFG_THROTTLE_MAX      = 3'd6
    } t_cfg_idx;

    // Stick word offset for the roll and pitch channels.
    localparam logic [15:0] TILT_ZERO_WORD = 16'd1024;

    // Throttle curve.
    localparam logic [7:0]       THR_MID_START  = 8'd64;
    localparam logic [7:0]       THR_HIGH_START = 8'd192;
    localparam logic [THR_W-1:0] THR_LOW_BASE   = 13'd2001;
    localparam logic [THR_W-1:0] THR_LOW_SLOPE  = 13'd17;
    localparam logic [THR_W-1:0] THR_MID_BASE   = 13'd3089;
    localparam logic [THR_W-1:0] THR_MID_SLOPE  = 13'd5;
    localparam logic [THR_W-1:0] THR_HIGH_BASE  = 13'd3729;
    localparam logic [THR_W-1:0] THR_HIGH_SLOPE = 13'd15;

    // Tilt curve, in degrees scaled by TILT_SCALE.
    localparam int TILT_CENTER      = 128;
    localparam int TILT_KNEE        = 60;
    localparam int TILT_INNER_SLOPE = 200;
    localparam int TILT_OUTER_SLOPE = 300;
    localparam int TILT_KNEE_VALUE  = 11904;
    localparam int TILT_SCALE       = 1280;
    localparam int TILT_MAX_ABS     = 32304;

    // Yaw map: -(s - 128) * 5 * 2^frac / 16.
    localparam int YAW_GAIN      = 5;
    localparam int YAW_SHIFT_DIV = 4;
    localparam int YAW_MAX_ABS   = 640;

    typedef struct packed {
        logic [THR_W-1:0]   throttle;
        logic [ANGLE_W-1:0] roll;
        logic [ANGLE_W-1:0] pitch;
        logic [YAW_W-1:0]   yaw;
    } t_stick_map;

    function automatic logic [7:0] sat_stick(input logic [14:0] v);
        return (|v[14:8]) ? 8'hff : v[7:0];
    endfunction

    function automatic logic [THR_W-1:0] throttle_map(input logic [7:0] s);
        logic [THR_W-1:0] v;
        logic [THR_W-1:0] hi;
        hi = THR_W'(s - THR_HIGH_START) * THR_HIGH_SLOPE;
        if (s < THR_MID_START) begin
            v = THR_LOW_BASE + THR_W'(s) * THR_LOW_SLOPE;
        end else if (s <= THR_HIGH_START) begin
            v = THR_MID_BASE + THR_W'(s - THR_MID_START) * THR_MID_SLOPE;
        end else begin
            v = THR_HIGH_BASE + (hi >> 1);
        end
        return v;
    endfunction

endpackage

@@ rtl/rpd_stick_map.sv @@
`timescale 1ns / 1ps

module rpd_stick_map #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic [rpd_pkg::STICK_BYTES-1:0][7:0] i_field,
    input  logic [rpd_pkg::TRIM_W-1:0]           i_roll_trim,
    input  logic [rpd_pkg::TRIM_W-1:0]           i_pitch_trim,
    output rpd_pkg::t_stick_map                  o_map
);
    import rpd_pkg::*;

    // Signed width of floor(angle * 2^frac / scale).
    localparam int QMAX = ((TILT_MAX_ABS << ANGLE_FRAC_BITS) / TILT_SCALE) + 2;
    localparam int QW   = $clog2(QMAX + 1) + 1;
    localparam int SW   = ((QW > ANGLE_W) ? QW : ANGLE_W) + 1;
    localparam int YW0  = $clog2((YAW_MAX_ABS << (ANGLE_FRAC_BITS - YAW_SHIFT_DIV)) + 1) + 1;
    localparam int YW   = (YW0 > ANGLE_W) ? YW0 : ANGLE_W;

    localparam logic signed [SW-1:0] ANG_MAX = SW'(32767);
    localparam logic signed [SW-1:0] ANG_MIN = SW'(-32768);
    localparam logic signed [YW-1:0] YAW_MAX = YW'(16383);
    localparam logic signed [YW-1:0] YAW_MIN = YW'(-16384);
    localparam logic signed [YW-1:0] YAW_K   = YW'(YAW_GAIN);
    localparam logic [9:0]           CENTER  = 10'(TILT_CENTER);

    // Each entry: {remainder nonzero, floor(tilt * 2^frac / scale)}.
    typedef logic [QW:0] t_tilt_tbl [256];

    function automatic t_tilt_tbl tilt_tbl_build();
        t_tilt_tbl tbl;
        int        d;
        int        a;
        longint    x;
        longint    q;
        logic      nz;
        for (int r = 0; r < 256; r++) begin
            d = r - TILT_CENTER;
            if (d > -TILT_KNEE && d < TILT_KNEE) begin
                a = d * TILT_INNER_SLOPE;
            end else if (d <= -TILT_KNEE) begin
                a = -TILT_KNEE_VALUE + (d + TILT_KNEE) * TILT_OUTER_SLOPE;
            end else begin
                a = TILT_KNEE_VALUE + (d - TILT_KNEE) * TILT_OUTER_SLOPE;
            end
            x  = longint'(a) * (longint'(1) << ANGLE_FRAC_BITS);
            q  = x / TILT_SCALE;
            nz = (x % TILT_SCALE) != 0;
            if (x < 0 && nz) begin
                q = q - 1;
            end
            tbl[r] = {nz, QW'(q)};
        end
        return tbl;
    endfunction

    localparam t_tilt_tbl TILT_TBL = tilt_tbl_build();

    // floor value plus trim, then truncation toward zero, then s16 saturation.
    function automatic logic [ANGLE_W-1:0] tilt_target(
        input logic signed [SW-1:0] q,
        input logic                 nz,
        input logic [TRIM_W-1:0]    trim
    );
        logic signed [SW-1:0] s;
        logic [ANGLE_W-1:0]   v;
        s = q + $signed({{(SW-TRIM_W){trim[TRIM_W-1]}}, trim});
        if (s < 0 && nz) begin
            s = s + SW'(1);
        end
        if (s > ANG_MAX) begin
            v = ANG_MAX[ANGLE_W-1:0];
        end else if (s < ANG_MIN) begin
            v = ANG_MIN[ANGLE_W-1:0];
        end else begin
            v = s[ANGLE_W-1:0];
        end
        return v;
    endfunction

    logic [16:0]          thr_word;
    logic [15:0]          roll_word;
    logic [15:0]          pitch_word;
    logic [7:0]           thr_stick;
    logic [7:0]           yaw_stick;
    logic [7:0]           roll_stick;
    logic [7:0]           pitch_stick;
    logic [QW:0]          roll_e;
    logic [QW:0]          pitch_e;
    logic signed [SW-1:0] roll_q;
    logic signed [SW-1:0] pitch_q;
    logic [9:0]           yaw_d;
    logic signed [YW-1:0] yaw_v;

    always_comb begin
        thr_word    = {1'b0, i_field[1], i_field[0]} + 17'd1;
        roll_word   = TILT_ZERO_WORD - {i_field[5], i_field[4]};
        pitch_word  = TILT_ZERO_WORD - {i_field[7], i_field[6]};
        thr_stick   = sat_stick(thr_word[16:2]);
        yaw_stick   = sat_stick({1'b0, i_field[3], i_field[2][7:2]});
        roll_stick  = sat_stick({1'b0, roll_word[15:2]});
        pitch_stick = sat_stick({1'b0, pitch_word[15:2]});

        roll_e  = TILT_TBL[roll_stick];
        pitch_e = TILT_TBL[pitch_stick];
        roll_q  = $signed({{(SW-QW){roll_e[QW-1]}}, roll_e[QW-1:0]});
        // Pitch uses the negated angle: floor(-x) = -(floor(x) + frac flag).
        pitch_q = -($signed({{(SW-QW){pitch_e[QW-1]}}, pitch_e[QW-1:0]})
                    + $signed(SW'(pitch_e[QW])));

        yaw_d = {2'b00, yaw_stick} - CENTER;
        yaw_v = -($signed({{(YW-10){yaw_d[9]}}, yaw_d}) * YAW_K);
        yaw_v = yaw_v <<< (ANGLE_FRAC_BITS - YAW_SHIFT_DIV);

        o_map.throttle = throttle_map(thr_stick);
        o_map.roll     = tilt_target(roll_q, roll_e[QW], i_roll_trim);
        o_map.pitch    = tilt_target(pitch_q, pitch_e[QW], i_pitch_trim);
        if (yaw_v > YAW_MAX) begin
            o_map.yaw = YAW_MAX[YAW_W-1:0];
        end else if (yaw_v < YAW_MIN) begin
            o_map.yaw = YAW_MIN[YAW_W-1:0];
        end else begin
            o_map.yaw = yaw_v[YAW_W-1:0];
        end
    end

endmodule

@@ rtl/remote_packet_decoder.sv @@
`timescale 1ns / 1ps
`include "remote_packet_decoder_macros.svh"

// Channel  | Direction | Handshake         | Payload
// ---------+-----------+-------------------+------------------------------------------
// input    | in        | i_valid / o_stall | i_cmd, i_rx_byte, i_packet_start
// result   | out       | o_valid / i_stall | o_from_packet .. o_link_lost
// config   | in        | i_cfg_we          | i_cfg_index, i_cfg_wdata
//
// One beat per cycle on the input while o_stall is low; a byte waits in the input
// register and, if it ends a packet (or is a tick), passes its result to the result
// register as it advances; all packet arithmetic is combinational in between.
// o_stall rises only while a last byte or a tick waits behind a result held by i_stall;
// other bytes keep flowing into the state registers.
// Reset (synchronous, i_rst_n low) clears state but r_field, loads default config.

module remote_packet_decoder #(
    parameter int SUM_BYTES       = 30,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_cmd,
    input  logic [7:0]                        i_rx_byte,
    input  logic                              i_packet_start,

    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_from_packet,
    output logic                              o_packet_ok,
    output logic [rpd_pkg::THR_W-1:0]         o_throttle,
    output logic signed [rpd_pkg::ANGLE_W-1:0] o_roll_target,
    output logic signed [rpd_pkg::ANGLE_W-1:0] o_pitch_target,
    output logic signed [rpd_pkg::YAW_W-1:0]  o_yaw_rate_target,
    output logic                              o_alt_hold,
    output logic                              o_launch_clear,
    output logic [15:0]                       o_fail_count,
    output logic                              o_link_lost,

    input  logic                              i_cfg_we,
    input  logic [rpd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rpd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import rpd_pkg::*;

    localparam logic [IDX_W-1:0] SUM_END  = IDX_W'(SUM_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);
    localparam logic [IDX_W-1:0] CHK_IDX  = IDX_W'(PACKET_BYTES - 2);

    // Configuration.
    logic [7:0]        r_release_threshold;
    logic [11:0]       r_rise_limit;
    logic [15:0]       r_fail_limit;
    logic [TRIM_W-1:0] r_roll_trim;
    logic [TRIM_W-1:0] r_pitch_trim;
    logic [THR_W-1:0]  r_throttle_min;
    logic [THR_W-1:0]  r_throttle_max;

    // Input register.
    logic       r_in_valid;
    logic       r_in_cmd;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // Decoder state.
    logic [IDX_W-1:0]   r_byte_index,    n_byte_index;
    logic [SUM_W-1:0]   r_running_sum,   n_running_sum;
    logic [7:0]         r_field [FIELD_DEPTH];
    logic [7:0]         n_field [FIELD_DEPTH];
    logic [THR_W-1:0]   r_throttle_now,  n_throttle_now;
    logic [THR_W-1:0]   r_throttle_prev, n_throttle_prev;
    logic [ANGLE_W-1:0] r_roll_hold,     n_roll_hold;
    logic [ANGLE_W-1:0] r_pitch_hold,    n_pitch_hold;
    logic [YAW_W-1:0]   r_yaw_hold,      n_yaw_hold;
    logic [1:0]         r_key_code,      n_key_code;
    logic               r_key_pending,   n_key_pending;
    logic [7:0]         r_release_count, n_release_count;
    logic               r_alt_hold,      n_alt_hold;
    logic [15:0]        r_fail_counter,  n_fail_counter;

    // Result register.
    logic               r_out_valid;
    logic               r_out_from_packet;
    logic               r_out_ok;
    logic [THR_W-1:0]   r_out_throttle;
    logic [ANGLE_W-1:0] r_out_roll;
    logic [ANGLE_W-1:0] r_out_pitch;
    logic [YAW_W-1:0]   r_out_yaw;
    logic               r_out_alt_hold;
    logic               r_out_clear;
    logic [15:0]        r_out_fail_count;
    logic               r_out_lost;

    logic               n_ok;
    logic               n_clear;
    logic               n_lost;

    logic [IDX_W-1:0]   w_idx;
    logic               is_tick;
    logic               last;
    logic               has_result;
    logic               out_free;
    logic               advance;
    logic               in_accept;
    logic [THR_W:0]     rise_bound;
    logic [SUM_W-1:0]   sum_base;

    logic [STICK_BYTES-1:0][7:0] stick_bytes;
    t_stick_map                  stick;

    always_comb begin
        for (int j = 0; j < STICK_BYTES; j++) begin
            stick_bytes[j] = r_field[j];
        end
    end

    rpd_stick_map #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_stick_map (
        .i_field      (stick_bytes),
        .i_roll_trim  (r_roll_trim),
        .i_pitch_trim (r_pitch_trim),
        .o_map        (stick)
    );

    // A byte that ends no packet never needs the result register, so it never waits.
    assign w_idx      = r_in_start ? '0 : r_byte_index;
    assign is_tick    = (r_in_cmd == CMD_TICK);
    assign last       = !is_tick && (w_idx == LAST_IDX);
    assign has_result = is_tick || last;
    assign out_free   = !r_out_valid || !i_stall;
    assign advance    = r_in_valid && (!has_result || out_free);
    assign o_stall    = r_in_valid && !advance;
    assign in_accept  = i_valid && !o_stall;

    always_comb begin
        n_byte_index    = r_byte_index;
        n_running_sum   = r_running_sum;
        n_field         = r_field;
        n_throttle_now  = r_throttle_now;
        n_throttle_prev = r_throttle_prev;
        n_roll_hold     = r_roll_hold;
        n_pitch_hold    = r_pitch_hold;
        n_yaw_hold      = r_yaw_hold;
        n_key_code      = r_key_code;
        n_key_pending   = r_key_pending;
        n_release_count = r_release_count;
        n_alt_hold      = r_alt_hold;
        n_fail_counter  = r_fail_counter;
        n_ok            = 1'b0;
        n_clear         = 1'b0;
        n_lost          = 1'b0;
        rise_bound      = '0;
        sum_base        = (w_idx == '0) ? '0 : r_running_sum;

        if (advance) begin
            if (is_tick) begin
                if (r_fail_counter > r_fail_limit) begin
                    n_fail_counter = '0;
                    n_throttle_now = '0;
                    n_lost         = 1'b1;
                end
            end else begin
                n_running_sum = sum_base;
                if (w_idx < SUM_END) begin
                    n_running_sum = sum_base + SUM_W'(r_in_byte);
                end
                for (int j = 0; j <= FIELD_LAST - FIELD_FIRST; j++) begin
                    if (w_idx == IDX_W'(j + FIELD_FIRST)) begin
                        n_field[j] = r_in_byte;
                    end
                end
                if (w_idx == CHK_IDX) begin
                    n_field[CHECK_SLOT] = r_in_byte;
                end
                n_byte_index = w_idx + IDX_W'(1);

                if (last) begin
                    n_ok = (r_running_sum != '0) && (r_running_sum < SUM_LIMIT)
                        && (r_field[CHECK_SLOT] == r_running_sum[7:0])
                        && (r_in_byte == {3'b000, r_running_sum[SUM_W-1:8]});
                    if (n_ok) begin
                        n_throttle_now  = stick.throttle;
                        n_throttle_prev = (r_throttle_prev == '0) ? stick.throttle
                                                                  : r_throttle_prev;
                        rise_bound = {1'b0, n_throttle_prev} + (THR_W + 1)'(r_rise_limit);
                        if ({1'b0, n_throttle_now} < rise_bound) begin
                            n_throttle_prev = n_throttle_now;
                        end else begin
                            n_throttle_now = n_throttle_prev;
                        end
                        n_fail_counter = '0;
                        n_roll_hold    = stick.roll;
                        n_pitch_hold   = stick.pitch;
                        n_yaw_hold     = stick.yaw;

                        // Key debounce: a press acts once enough keyless packets follow.
                        if (r_field[KEY_SLOT] == {6'd0, KEY_ALT}
                            || r_field[KEY_SLOT] == {6'd0, KEY_AUX}) begin
                            n_key_code      = r_field[KEY_SLOT][1:0];
                            n_key_pending   = 1'b1;
                            n_release_count = '0;
                        end else if (r_release_count != 8'hff) begin
                            n_release_count = r_release_count + 8'd1;
                        end
                        if (n_release_count > r_release_threshold && n_key_pending) begin
                            if (n_key_code == KEY_ALT) begin
                                n_alt_hold = !r_alt_hold;
                                n_clear    = r_alt_hold;
                            end
                            n_release_count = '0;
                            n_key_pending   = 1'b0;
                        end
                    end else if (!(&r_fail_counter)) begin
                        n_fail_counter = r_fail_counter + 16'd1;
                    end

                    // When the limits cross, the upper bound wins only for a value above it.
                    if (n_throttle_now > r_throttle_max) begin
                        n_throttle_now = r_throttle_max;
                    end else if (n_throttle_now < r_throttle_min) begin
                        n_throttle_now = r_throttle_min;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_threshold <= 8'd20;
            r_rise_limit        <= 12'd1000;
            r_fail_limit        <= 16'd300;
            r_roll_trim         <= '0;
            r_pitch_trim        <= '0;
            r_throttle_min      <= 13'd2250;
            r_throttle_max      <= 13'd4500;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RELEASE_THRESHOLD: begin
                    r_release_threshold <= i_cfg_wdata[7:0];
                end
                CFG_RISE_LIMIT: begin
                    r_rise_limit <= i_cfg_wdata[11:0];
                end
                CFG_FAIL_LIMIT: begin
                    r_fail_limit <= i_cfg_wdata;
                end
                CFG_ROLL_TRIM: begin
                    r_roll_trim <= i_cfg_wdata[TRIM_W-1:0];
                end
                CFG_PITCH_TRIM: begin
                    r_pitch_trim <= i_cfg_wdata[TRIM_W-1:0];
                end
                CFG_THROTTLE_MIN: begin
                    r_throttle_min <= i_cfg_wdata[THR_W-1:0];
                end
                CFG_THROTTLE_MAX: begin
                    r_throttle_max <= i_cfg_wdata[THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_byte_index    <= '0;
            r_running_sum   <= '0;
            r_throttle_now  <= '0;
            r_throttle_prev <= '0;
            r_roll_hold     <= '0;
            r_pitch_hold    <= '0;
            r_yaw_hold      <= '0;
            r_key_code      <= '0;
            r_key_pending   <= 1'b0;
            r_release_count <= '0;
            r_alt_hold      <= 1'b0;
            r_fail_counter  <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && has_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            r_byte_index    <= n_byte_index;
            r_running_sum   <= n_running_sum;
            r_throttle_now  <= n_throttle_now;
            r_throttle_prev <= n_throttle_prev;
            r_roll_hold     <= n_roll_hold;
            r_pitch_hold    <= n_pitch_hold;
            r_yaw_hold      <= n_yaw_hold;
            r_key_code      <= n_key_code;
            r_key_pending   <= n_key_pending;
            r_release_count <= n_release_count;
            r_alt_hold      <= n_alt_hold;
            r_fail_counter  <= n_fail_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd   <= i_cmd;
            r_in_byte  <= i_rx_byte;
            r_in_start <= i_packet_start;
        end
        r_field <= n_field;
        if (advance && has_result) begin
            r_out_from_packet <= !is_tick;
            r_out_ok          <= n_ok;
            r_out_throttle    <= n_throttle_now;
            r_out_roll        <= n_roll_hold;
            r_out_pitch       <= n_pitch_hold;
            r_out_yaw         <= n_yaw_hold;
            r_out_alt_hold    <= n_alt_hold;
            r_out_clear       <= n_clear;
            r_out_fail_count  <= n_fail_counter;
            r_out_lost        <= n_lost;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_from_packet     = r_out_from_packet;
    assign o_packet_ok       = r_out_ok;
    assign o_throttle        = r_out_throttle;
    assign o_roll_target     = r_out_roll;
    assign o_pitch_target    = r_out_pitch;
    assign o_yaw_rate_target = r_out_yaw;
    assign o_alt_hold        = r_out_alt_hold;
    assign o_launch_clear    = r_out_clear;
    assign o_fail_count      = r_out_fail_count;
    assign o_link_lost       = r_out_lost;

    `RPD_ASSERT_IMP(a_tick_flags, i_clk, i_rst_n, o_valid && !o_from_packet, !o_packet_ok && !o_launch_clear, "tick beat carries packet flags")
    `RPD_ASSERT_IMP(a_lost_zeroes, i_clk, i_rst_n, o_valid && o_link_lost, o_throttle == '0 && o_fail_count == '0, "link loss did not cut throttle")
    `RPD_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, r_in_valid && r_out_valid && i_stall, "input stalled without a held result")
    `RPD_ASSERT_NXT(a_last_result, i_clk, i_rst_n, advance && last, o_valid && o_from_packet, "packet end produced no result beat")
    `RPD_ASSERT_IMP(a_key_code, i_clk, i_rst_n, r_key_pending, r_key_code == KEY_ALT || r_key_code == KEY_AUX, "pending key has no valid code")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import rpd_pkg::*;

    localparam int SUM_N = 30;
    localparam int FRAC  = 8;

    typedef struct {
        logic               from_packet;
        logic               ok;
        logic [THR_W-1:0]   throttle;
        logic [ANGLE_W-1:0] roll;
        logic [ANGLE_W-1:0] pitch;
        logic [YAW_W-1:0]   yaw;
        logic               alt;
        logic               clear;
        logic [15:0]        fails;
        logic               lost;
    } t_decode_result;

    class decoder_predictor;
        int unsigned release_thr, rise_lim, fail_lim, thr_floor, thr_ceil;
        int          roll_trim, pitch_trim;

        int unsigned byte_idx, running_total, thr_now, thr_prev;
        logic [7:0]  field_b [10];
        int          roll_hold, pitch_hold, yaw_hold;
        int unsigned key_code, key_pending, release_cnt, alt_flag, fail_cnt;

        t_decode_result expected_decodes [$];
        int             mismatches;

        function new();
            release_thr = 20;
            rise_lim    = 1000;
            fail_lim    = 300;
            thr_floor   = 2250;
            thr_ceil    = 4500;
            foreach (field_b[i]) field_b[i] = 8'h00;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_RELEASE_THRESHOLD: release_thr = v[7:0];
                CFG_RISE_LIMIT:        rise_lim    = v[11:0];
                CFG_FAIL_LIMIT:        fail_lim    = v;
                CFG_ROLL_TRIM:         roll_trim   = $signed(v[TRIM_W-1:0]);
                CFG_PITCH_TRIM:        pitch_trim  = $signed(v[TRIM_W-1:0]);
                CFG_THROTTLE_MIN:      thr_floor   = v[THR_W-1:0];
                CFG_THROTTLE_MAX:      thr_ceil    = v[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function int clip_stick(int unsigned v);
            return (v > 255) ? 255 : int'(v);
        endfunction

        function int unsigned throttle_curve(int s);
            if (s < 64) return 2001 + 17 * s;
            if (s <= 192) return 3089 + 5 * (s - 64);
            return 3729 + ((s - 192) * 15) / 2;
        endfunction

        // Tilt in degrees times 1280, with the knee at 60 counts off center.
        function int tilt_scaled(int r);
            int d;
            d = r - 128;
            if (d > -60 && d < 60) return d * 200;
            if (d <= -60) return -11904 + (d + 60) * 300;
            return 11904 + (d - 60) * 300;
        endfunction

        function int tilt_angle(int a, int trim);
            longint n;
            n = longint'(a) * (longint'(1) << FRAC) + longint'(trim) * 1280;
            n = n / 1280;
            if (n < -32768) n = -32768;
            else if (n > 32767) n = 32767;
            return int'(n);
        endfunction

        function void decode_beat(logic cmd, logic [7:0] b, logic st);
            int unsigned    idx, thr, yw, rl, pt;
            longint         yn;
            t_decode_result r;
            r.ok    = 1'b0;
            r.clear = 1'b0;
            r.lost  = 1'b0;
            if (cmd == CMD_TICK) begin
                if (fail_cnt > fail_lim) begin
                    fail_cnt = 0;
                    thr_now  = 0;
                    r.lost   = 1'b1;
                end
            end else begin
                idx = st ? 0 : byte_idx;
                if (idx == 0) running_total = 0;
                if (idx < SUM_N) running_total = (running_total + b) & 32'h1fff;
                if (idx >= 2 && idx <= 10) field_b[idx - 2] = b;
                if (idx == 30) field_b[9] = b;
                byte_idx = (idx + 1) & 32'h1f;
                if (idx != 31) return;

                r.ok = (running_total != 0) && (running_total < SUM_LIMIT) &&
                       (field_b[9] == running_total[7:0]) && (b == (running_total >> 8));
                if (r.ok) begin
                    thr = {field_b[1], field_b[0]} + 1;
                    yw  = {field_b[3], field_b[2]};
                    rl  = (1024 - {field_b[5], field_b[4]}) & 32'hffff;
                    pt  = (1024 - {field_b[7], field_b[6]}) & 32'hffff;

                    thr_now = throttle_curve(clip_stick(thr >> 2));
                    if (thr_prev == 0) thr_prev = thr_now;
                    if (thr_now < thr_prev + rise_lim) thr_prev = thr_now;
                    else thr_now = thr_prev;
                    fail_cnt = 0;

                    roll_hold  = tilt_angle(tilt_scaled(clip_stick(rl >> 2)), roll_trim);
                    pitch_hold = tilt_angle(-tilt_scaled(clip_stick(pt >> 2)), pitch_trim);
                    yn = -(longint'(clip_stick(yw >> 2)) - 128) * 5 * (longint'(1) << FRAC);
                    yn = yn / 16;
                    if (yn < -16384) yn = -16384;
                    else if (yn > 16383) yn = 16383;
                    yaw_hold = int'(yn);

                    // Key debounce: a press only acts after enough keyless packets.
                    if (field_b[8] == KEY_ALT || field_b[8] == KEY_AUX) begin
                        key_code    = field_b[8];
                        key_pending = 1;
                        release_cnt = 0;
                    end else if (release_cnt < 255) begin
                        release_cnt++;
                    end
                    if (release_cnt > release_thr && key_pending != 0) begin
                        if (key_code == KEY_ALT) begin
                            if (alt_flag != 0) r.clear = 1'b1;
                            alt_flag = (alt_flag != 0) ? 0 : 1;
                        end
                        release_cnt = 0;
                        key_pending = 0;
                    end
                end else if (fail_cnt < 65535) begin
                    fail_cnt++;
                end
                // When the limits cross, the upper clamp wins only for a value above it.
                if (thr_now > thr_ceil) thr_now = thr_ceil;
                else if (thr_now < thr_floor) thr_now = thr_floor;
            end
            r.from_packet = (cmd == CMD_BYTE);
            r.throttle    = thr_now[THR_W-1:0];
            r.roll        = roll_hold[ANGLE_W-1:0];
            r.pitch       = pitch_hold[ANGLE_W-1:0];
            r.yaw         = yaw_hold[YAW_W-1:0];
            r.alt         = alt_flag[0];
            r.fails       = fail_cnt[15:0];
            expected_decodes.push_back(r);
        endfunction

        function string describe(t_decode_result r);
            return $sformatf({"pkt=%0b ok=%0b thr=%0d roll=%0d pitch=%0d yaw=%0d",
                              " alt=%0b clr=%0b fails=%0d lost=%0b"},
                             r.from_packet, r.ok, r.throttle, $signed(r.roll),
                             $signed(r.pitch), $signed(r.yaw), r.alt, r.clear, r.fails, r.lost);
        endfunction

        function void check_decode(t_decode_result got);
            t_decode_result want;
            if (expected_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with no decode pending: %s", $time, describe(got));
                return;
            end
            want = expected_decodes.pop_front();
            if (got.from_packet !== want.from_packet || got.ok !== want.ok ||
                got.throttle !== want.throttle || got.roll !== want.roll ||
                got.pitch !== want.pitch || got.yaw !== want.yaw || got.alt !== want.alt ||
                got.clear !== want.clear || got.fails !== want.fails ||
                got.lost !== want.lost) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: decode mismatch", $time);
                    $display("  want %s", describe(want));
                    $display("  got  %s", describe(got));
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_cmd = CMD_BYTE;
    logic [7:0] i_rx_byte = 8'h00;
    logic i_packet_start = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_from_packet, o_packet_ok, o_alt_hold, o_launch_clear, o_link_lost;
    logic [THR_W-1:0] o_throttle;
    logic signed [ANGLE_W-1:0] o_roll_target, o_pitch_target;
    logic signed [YAW_W-1:0] o_yaw_rate_target;
    logic [15:0] o_fail_count;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_RELEASE_THRESHOLD;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    decoder_predictor predictor = new();
    logic [7:0] pkt [32];
    int snd_idle_pct = 15;
    int rcv_stall_pct = 68;
    int beats_sent = 0;

    remote_packet_decoder #(
        .SUM_BYTES       (SUM_N),
        .ANGLE_FRAC_BITS (FRAC)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_rx_byte         (i_rx_byte),
        .i_packet_start    (i_packet_start),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_from_packet     (o_from_packet),
        .o_packet_ok       (o_packet_ok),
        .o_throttle        (o_throttle),
        .o_roll_target     (o_roll_target),
        .o_pitch_target    (o_pitch_target),
        .o_yaw_rate_target (o_yaw_rate_target),
        .o_alt_hold        (o_alt_hold),
        .o_launch_clear    (o_launch_clear),
        .o_fail_count      (o_fail_count),
        .o_link_lost       (o_link_lost),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    always @(posedge i_clk) begin : watch_ports
        t_decode_result seen;
        if (i_rst_n) begin
            if (i_valid && !o_stall) predictor.decode_beat(i_cmd, i_rx_byte, i_packet_start);
            if (o_valid && !i_stall) begin
                seen.from_packet = o_from_packet;
                seen.ok          = o_packet_ok;
                seen.throttle    = o_throttle;
                seen.roll        = o_roll_target;
                seen.pitch       = o_pitch_target;
                seen.yaw         = o_yaw_rate_target;
                seen.alt         = o_alt_hold;
                seen.clear       = o_launch_clear;
                seen.fails       = o_fail_count;
                seen.lost        = o_link_lost;
                predictor.check_decode(seen);
            end
        end
    end

    // The valid line is touched once per step: either lowered for a gap or
    // driven high with the next beat.
    task automatic send_beat(logic cmd, logic [7:0] b, logic st);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_rx_byte      <= b;
        i_packet_start <= st;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_packet(int n, logic first_start);
        for (int i = 0; i < n; i++) send_beat(CMD_BYTE, pkt[i], (i == 0) ? first_start : 1'b0);
    endtask

    task automatic seal_packet();
        int unsigned total;
        total = 0;
        for (int i = 0; i < SUM_N; i++) total += pkt[i];
        pkt[30] = total[7:0];
        pkt[31] = total[15:8];
    endtask

    task automatic make_packet(logic [15:0] thr_w, logic [15:0] yaw_w, logic [15:0] roll_w,
                               logic [15:0] pitch_w, logic [7:0] key_b);
        int unsigned total;
        for (int i = 0; i < 32; i++) pkt[i] = 8'($urandom_range(255));
        {pkt[3], pkt[2]} = thr_w;
        {pkt[5], pkt[4]} = yaw_w;
        {pkt[7], pkt[6]} = roll_w;
        {pkt[9], pkt[8]} = pitch_w;
        pkt[10] = key_b;
        total = 0;
        for (int i = 0; i < SUM_N; i++) total += pkt[i];
        // Keep a well-formed packet under the sum limit by thinning the filler bytes.
        if (total >= SUM_LIMIT) begin
            pkt[0] = pkt[0] >> 2;
            pkt[1] = pkt[1] >> 2;
            for (int i = 11; i < SUM_N; i++) pkt[i] = pkt[i] >> 2;
        end
        seal_packet();
    endtask

    task automatic fill_packet(logic [7:0] v);
        for (int i = 0; i < 32; i++) pkt[i] = v;
        seal_packet();
    endtask

    function automatic logic [15:0] random_stick(bit tilt);
        int unsigned s;
        s = $urandom_range(1023);
        if ($urandom_range(4) == 0) return 16'($urandom);
        return tilt ? 16'(1024 - s) : 16'(s);
    endfunction

    function automatic logic [7:0] random_key();
        int k;
        k = $urandom_range(9);
        if (k < 3) return 8'(KEY_ALT);
        if (k == 3) return 8'(KEY_AUX);
        return 8'($urandom_range(255));
    endfunction

    task automatic make_random_packet();
        make_packet(random_stick(0), random_stick(0), random_stick(1), random_stick(1),
                    random_key());
    endtask

    task automatic settle(int tail);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (predictor.expected_decodes.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        predictor.set_reg(idx, v);
    endtask

    task automatic load_config(int rel, int rise, int fails, int rtrim, int ptrim,
                               int tmin, int tmax);
        write_reg(CFG_RELEASE_THRESHOLD, 16'(rel));
        write_reg(CFG_RISE_LIMIT, 16'(rise));
        write_reg(CFG_FAIL_LIMIT, 16'(fails));
        write_reg(CFG_ROLL_TRIM, 16'(rtrim));
        write_reg(CFG_PITCH_TRIM, 16'(ptrim));
        write_reg(CFG_THROTTLE_MIN, 16'(tmin));
        write_reg(CFG_THROTTLE_MAX, 16'(tmax));
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_chunk();
        int k;
        k = $urandom_range(99);
        if (k < 60) begin
            make_random_packet();
            send_packet(32, $urandom_range(6) != 0);
        end else if (k < 70) begin
            send_beat(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end else if (k < 76) begin
            make_random_packet();
            pkt[30 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
            send_packet(32, 1'b1);
        end else if (k < 80) begin
            fill_packet($urandom_range(1) ? 8'hff : 8'h00);
            send_packet(32, 1'b1);
        end else if (k < 88) begin
            make_random_packet();
            send_packet(1 + $urandom_range(30), 1'b1);
        end else begin
            repeat (1 + $urandom_range(7))
                send_beat(CMD_BYTE, 8'($urandom_range(255)), $urandom_range(9) == 0);
        end
    endtask

    initial begin
        int  phase_start;
        bit  paused;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset configuration.
        send_beat(CMD_TICK, 8'h5a, 1'b1);
        make_packet(16'h0000, 16'h0000, 16'd1024, 16'hffff, 8'(KEY_ALT));
        send_packet(32, 1'b1);
        make_packet(16'hffff, 16'hffff, 16'd4, 16'd516, 8'h00);
        send_packet(32, 1'b1);
        // Knee points of the tilt curve and the throttle segment edges.
        make_packet(16'd255, 16'd512, 16'd752, 16'd272, 8'(KEY_AUX));
        send_packet(32, 1'b0);
        make_packet(16'd767, 16'd516, 16'd748, 16'd276, 8'h03);
        send_packet(32, 1'b0);
        make_packet(16'd771, 16'd1023, 16'd0, 16'd1024, 8'h00);
        send_packet(32, 1'b1);
        fill_packet(8'h00);
        send_packet(32, 1'b1);
        fill_packet(8'hff);
        send_packet(32, 1'b1);
        make_packet(16'd400, 16'd300, 16'd600, 16'd700, 8'(KEY_ALT));
        pkt[30] ^= 8'h01;
        send_packet(32, 1'b1);
        make_packet(16'd500, 16'd500, 16'd500, 16'd500, 8'h00);
        send_packet(10, 1'b1);
        send_beat(CMD_TICK, 8'ha5, 1'b0);

        for (int p = 0; p < 6; p++) begin
            settle(4);
            case (p / 2)
                0: begin snd_idle_pct = 15; rcv_stall_pct = 68; end
                1: begin snd_idle_pct = 68; rcv_stall_pct = 15; end
                default: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
            endcase
            case (p)
                0: load_config(0, 4095, 0, 8192, -8192, 0, 8191);
                1: load_config(255, 0, 65535, -8192, 8192, 8191, 0);
                2: load_config(1, 1000, 1, 100, -37, 2250, 4500);
                3: load_config(2, $urandom_range(4095), 2, $urandom_range(16384) - 8192,
                               $urandom_range(16384) - 8192, $urandom_range(3000),
                               3000 + $urandom_range(5191));
                4: load_config($urandom_range(3), $urandom_range(4095), $urandom_range(3),
                               $urandom_range(16384) - 8192, $urandom_range(16384) - 8192,
                               $urandom_range(8191), $urandom_range(8191));
                default: load_config(0, 300, 0, -1, 1, 2600, 3800);
            endcase
            phase_start = beats_sent;
            paused = 0;
            while (beats_sent - phase_start < 250) begin
                if (!paused && beats_sent - phase_start >= 125) begin
                    settle(0);
                    paused = 1;
                end
                random_chunk();
            end
        end

        settle(10);
        if (predictor.mismatches == 0 && predictor.expected_decodes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
